FILE: hw/rtl/ofvf_pkg.sv
package ofvf_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_STEP_PERIOD = 3'd0;
    localparam logic [2:0] REG_FLOW_SCALE  = 3'd1;
    localparam logic [2:0] REG_LP_ALPHA    = 3'd2;
    localparam logic [2:0] REG_FUSION_GAIN = 3'd3;
    localparam logic [2:0] REG_LEAK        = 3'd4;

    // Reset values of the registers.
    localparam logic [15:0] RST_STEP_PERIOD = 16'd655;
    localparam logic [30:0] RST_FLOW_SCALE  = 31'd65536;
    localparam logic [16:0] RST_LP_ALPHA    = 17'd16384;
    localparam logic [16:0] RST_FUSION_GAIN = 17'd32768;
    localparam logic [16:0] RST_LEAK        = 17'd64225;

    // pi/180 in Q0.32.
    localparam logic signed [32:0] DEG2RAD_Q32 = 33'sd74961321;
    localparam logic [16:0] Q_ONE = 17'd65536;

    // Quotient width of the flow divider: 16-bit magnitude shifted by 48.
    localparam int QW = 64;

    // Saturate a 66-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

FILE: hw/rtl/optical_flow_velocity_fusion_core.sv
// Optical-flow / acceleration velocity fusion core.
// Input channel s_axis: one request per sensor tick with flow counts, gyro
// rates, world acceleration and height. Output channel m_axis: one result
// with low-passed flow velocity, fused velocity and position of both axes.
// Configuration: write i_cfg_we with register index and data while idle.
// Each request is worked one axis after the other: a divider start
// state, the shared restoring divider (64 quotient bits, one per cycle),
// then seven steps on the shared registered multiplier, each a multiply
// state and a wait state. s_axis_tready is low while a request is in
// work or its result waits; a stalled receiver keeps the result held in
// the output register and the next request waits.
// Reset (synchronous, active low) clears all filter state to zero and sets
// the registers to their defaults.
module optical_flow_velocity_fusion_core
    import ofvf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // flow_dx, flow_dy, rate_about_x, rate_about_y, accel_x, accel_y,
    // height_m, zero fill
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // flow_vel_x, flow_vel_y, fused_vel_x, fused_vel_y, pos_x, pos_y
    output logic [191:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [30:0]  i_cfg_data
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_MUL  = 6'b000100,
        S_WAIT = 6'b001000,
        S_OUT  = 6'b010000,
        S_DSTR = 6'b100000
    } t_state;

    t_state r_state;
    logic [15:0] r_period;
    logic [30:0] r_scale;
    logic [16:0] r_alpha, r_gain, r_leak;
    logic signed [31:0] r_lp [2];
    logic signed [31:0] r_vel [2];
    logic signed [31:0] r_pos [2];
    logic [159:0] r_in;
    logic         r_axis;
    logic [2:0]   r_step;
    logic signed [31:0] r_rate, r_t;
    logic         r_ovalid;
    logic [16:0]  w_cfg17;

    // Configuration writes, coefficients clamped to one.
    assign w_cfg17 = (i_cfg_data[16:0] > Q_ONE) ? Q_ONE : i_cfg_data[16:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RST_STEP_PERIOD;
            r_scale  <= RST_FLOW_SCALE;
            r_alpha  <= RST_LP_ALPHA;
            r_gain   <= RST_FUSION_GAIN;
            r_leak   <= RST_LEAK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STEP_PERIOD: r_period <= i_cfg_data[15:0];
                REG_FLOW_SCALE:  r_scale  <= i_cfg_data;
                REG_LP_ALPHA:    r_alpha  <= w_cfg17;
                REG_FUSION_GAIN: r_gain   <= w_cfg17;
                REG_LEAK:        r_leak   <= w_cfg17;
                default: ;
            endcase
        end
    end

    // Field selects of the held request for the current axis.
    logic signed [15:0] w_d;
    logic signed [27:0] w_g;
    logic signed [24:0] w_acc;
    logic [19:0]        w_h;
    assign w_d   = r_axis ? r_in[31:16] : r_in[15:0];
    assign w_g   = r_axis ? r_in[59:32] : r_in[87:60];
    assign w_acc = r_axis ? r_in[137:113] : r_in[112:88];
    assign w_h   = r_in[157:138];

    // Divider on |d| and the denominator period*scale.
    logic        w_dstart, w_ddone;
    logic [63:0] w_quot;
    logic [46:0] w_den;
    assign w_den = 47'(r_period) * 47'(r_scale);
    assign w_dstart = (r_state == S_DSTR);
    ofvf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_mag(w_d[15] ? 16'(-w_d) : w_d), .i_den(w_den),
        .o_done(w_ddone), .o_quot(w_quot)
    );

    // Multiplier operand select per sequencer step.
    logic signed [32:0] w_a, w_b;
    logic               w_s32;
    logic signed [65:0] w_p;
    logic signed [31:0] w_lp, w_vel, w_pos;
    assign w_lp  = r_lp[r_axis];
    assign w_vel = r_vel[r_axis];
    assign w_pos = r_pos[r_axis];
    always_comb begin
        w_s32 = 1'b0;
        w_a   = '0;
        w_b   = '0;
        case (r_step)
            3'd0: begin w_a = 33'(w_g); w_b = DEG2RAD_Q32; w_s32 = 1'b1; end
            3'd1: begin w_a = 33'(r_t); w_b = 33'(w_h); end
            3'd2: begin w_a = 33'(r_t) - 33'(w_lp); w_b = 33'(r_alpha); end
            3'd3: begin w_a = 33'(w_acc); w_b = 33'(r_period); end
            3'd4: begin w_a = 33'(r_t); w_b = 33'(r_leak); end
            3'd5: begin w_a = 33'(w_lp) - 33'(r_t); w_b = 33'(r_gain); end
            default: begin w_a = 33'(r_t); w_b = 33'(r_period); end
        endcase
    end
    ofvf_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .i_s32(w_s32), .o_p(w_p));

    // Saturated flow rate from the quotient.
    logic signed [31:0] w_frate;
    always_comb begin
        if (w_den == '0) begin
            w_frate = '0;
        end else if (w_d[15]) begin
            w_frate = (w_quot > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-w_quot);
        end else begin
            w_frate = (w_quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : w_quot[31:0];
        end
    end

    // Sequencer: divide, then multiplier steps, each followed by a wait state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_axis   <= 1'b0;
            r_step   <= '0;
            r_lp[0] <= '0; r_lp[1] <= '0;
            r_vel[0] <= '0; r_vel[1] <= '0;
            r_pos[0] <= '0; r_pos[1] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_in    <= s_axis_tdata;
                    r_axis  <= 1'b0;
                    r_state <= S_DSTR;
                end
                S_DSTR: r_state <= S_DIV;
                S_DIV: if (w_ddone) begin
                    r_rate  <= w_frate;
                    r_step  <= 3'd0;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_WAIT;
                S_WAIT: begin
                    r_state <= S_MUL;
                    r_step  <= r_step + 3'd1;
                    case (r_step)
                        3'd0: r_t <= sat32(66'(r_rate) - w_p);
                        3'd1: r_t <= sat32(w_p);
                        3'd2: begin
                            r_lp[r_axis] <= sat32(66'(w_lp) + w_p);
                            r_t <= w_vel;
                        end
                        3'd3: r_t <= sat32(66'(r_t) + w_p);
                        3'd4: r_t <= sat32(w_p);
                        3'd5: r_t <= sat32(66'(r_t) + w_p);
                        default: begin
                            r_vel[r_axis] <= r_t;
                            r_pos[r_axis] <= sat32(66'(w_pos) + w_p);
                            if (r_axis) begin
                                r_ovalid <= 1'b1;
                                r_state  <= S_OUT;
                            end else begin
                                r_axis  <= 1'b1;
                                r_state <= S_DSTR;
                            end
                        end
                    endcase
                end
                S_OUT: if (m_axis_tready) begin
                    r_ovalid <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_pos[1], r_pos[0], r_vel[1], r_vel[0], r_lp[1], r_lp[0]};
endmodule

FILE: hw/rtl/ofvf_div.sv
// Restoring divider, one quotient bit per cycle: (mag << 48) / den.
module ofvf_div
    import ofvf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_mag,
    input  logic [46:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_num;
    logic [63:0] r_quot;
    logic [47:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [47:0] w_try;

    assign w_try  = {r_rem[46:0], r_num[63]};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_num  <= {i_mag, 48'd0};
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                // Shift in one numerator bit and try the subtraction.
                r_num <= {r_num[62:0], 1'b0};
                if (w_try >= {1'b0, i_den}) begin
                    r_rem  <= w_try - {1'b0, i_den};
                    r_quot <= {r_quot[62:0], 1'b1};
                end else begin
                    r_rem  <= w_try;
                    r_quot <= {r_quot[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: hw/rtl/ofvf_mul.sv
// Shared signed multiplier with rounding: round(a*b / 2^s), ties away from
// zero. One registered result per cycle.
module ofvf_mul
    import ofvf_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    input  logic               i_s32,
    output logic signed [65:0] o_p
);
    logic               w_neg;
    logic        [32:0] w_ma;
    logic        [32:0] w_mb;
    logic        [65:0] w_prod;
    logic        [65:0] w_rnd;
    logic signed [65:0] r_p;

    assign w_neg  = i_a[32] ^ i_b[32];
    assign w_ma   = i_a[32] ? 33'(-i_a) : i_a;
    assign w_mb   = i_b[32] ? 33'(-i_b) : i_b;
    assign w_prod = 66'(w_ma) * 66'(w_mb);
    assign w_rnd  = i_s32 ? ((w_prod + 66'h8000_0000) >> 32)
                          : ((w_prod + 66'h8000) >> 16);

    always_ff @(posedge i_clk) begin
        r_p <= w_neg ? -$signed(w_rnd) : $signed(w_rnd);
    end
    assign o_p = r_p;
endmodule
